// ===== rtl/core/i2c_bit_level_master_macros.svh =====
// Assertion macros for the I2C bit-level master.
// Used by i2c_bit_level_master.sv; expects clk_i and rst_ni in scope.
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define I2CBLM_ASSERT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define I2CBLM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/i2cblm_pkg.sv =====
// Package for the I2C bit-level master: command codes, register indexes,
// reset values and the input and result item structs. No dependencies.
package i2cblm_pkg;

  // Bus commands
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_WAIT_ACK = 3'd4,
    CMD_READ     = 3'd5,
    CMD_ACK      = 3'd6,
    CMD_NACK     = 3'd7
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WAIT_TICKS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 2'd1;

  localparam int unsigned WaitW = 16;
  localparam int unsigned PollW = 18;
  localparam int unsigned CfgDataW = 18;

  localparam logic [WaitW-1:0] WAIT_TICKS_RST  = 16'd40;
  localparam logic [PollW-1:0] ACK_TIMEOUT_RST = 18'd120000;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       ready_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       ack_valid;
    logic       ack_seen;
  } out_item_t;

endpackage

// ===== rtl/core/i2c_bit_level_master.sv =====
// I2C bit-level master: one tick item in, one pin/status item out.
// The result of an item is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while no result is held stalled; the phase sequencer advances once per accepted item.
// Input stall follows output stall only while a result is still held.
// Reset: idle, SCL/SDA high and driven, wait 40 ticks, ack timeout 120000, no result held.
// Depends on i2cblm_pkg and i2c_bit_level_master_macros.svh.
module i2c_bit_level_master (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  i2cblm_pkg::in_item_t              in_item_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output i2cblm_pkg::out_item_t             out_item_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [i2cblm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [i2cblm_pkg::CfgDataW-1:0]   cfg_data_i
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C,
    PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
    PH_WA_A, PH_WA_POLL, PH_WA_C, PH_WA_D,
    PH_WR_PRE, PH_WR_LOW, PH_WR_DATA, PH_WR_HIGH, PH_WR_END,
    PH_RD_PRE, PH_RD_LOW, PH_RD_HIGH,
    PH_AK_A, PH_AK_B, PH_AK_C, PH_AK_D, PH_AK_E
  } phase_e;

  localparam int unsigned WaitW = i2cblm_pkg::WaitW;
  localparam int unsigned PollW = i2cblm_pkg::PollW;

  // state
  phase_e                 phase_q, phase_d;
  i2cblm_pkg::cmd_e       cmd_q, cmd_d;
  logic [3:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic [WaitW-1:0]       wait_q, wait_d;
  logic [PollW-1:0]       poll_q, poll_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   drive_q, drive_d;
  logic [7:0]             rbyte_q, rbyte_d;
  logic                   ack_q, ack_d;
  logic                   pulse_read, pulse_ack;
  // configuration
  logic [WaitW-1:0]       wait_ticks_q;
  logic [PollW-1:0]       ack_timeout_q;
  // result register
  logic                   out_valid_q, out_valid_d;
  i2cblm_pkg::out_item_t  out_q, out_d;

  logic                   accept;
  logic [WaitW-1:0]       half_ticks;
  logic [WaitW-1:0]       full_m1, half_m1;
  logic [3:0]             bit_inc;
  logic [7:0]             shift_rd;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // phase reload values, clamped to at least one tick
  assign half_ticks = wait_ticks_q >> 1;
  assign full_m1    = (wait_ticks_q == '0) ? '0 : wait_ticks_q - 1'b1;
  assign half_m1    = (half_ticks == '0) ? '0 : half_ticks - 1'b1;
  assign bit_inc    = bit_q + 4'd1;
  assign shift_rd   = {shift_q[6:0], in_item_i.sda_in};

  // next state for one tick
  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    wait_d     = wait_q;
    poll_d     = poll_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    drive_d    = drive_q;
    rbyte_d    = rbyte_q;
    ack_d      = ack_q;
    pulse_read = 1'b0;
    pulse_ack  = 1'b0;

    if (phase_q == PH_IDLE) begin
      // new command
      if (in_item_i.command != i2cblm_pkg::CMD_NONE) begin
        cmd_d = in_item_i.command;
        case (in_item_i.command)
          i2cblm_pkg::CMD_START: begin
            drive_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
            phase_d = PH_ST_A; wait_d = full_m1;
          end
          i2cblm_pkg::CMD_STOP: begin
            drive_d = 1'b1; scl_d = 1'b0;
            phase_d = PH_SP_A; wait_d = full_m1;
          end
          i2cblm_pkg::CMD_WRITE: begin
            drive_d = 1'b1; shift_d = in_item_i.write_data;
            phase_d = PH_WR_PRE; wait_d = half_m1;
          end
          i2cblm_pkg::CMD_WAIT_ACK: begin
            drive_d = 1'b0; scl_d = 1'b0; sda_d = 1'b1;
            phase_d = PH_WA_A; wait_d = full_m1;
          end
          i2cblm_pkg::CMD_READ: begin
            drive_d = 1'b0; sda_d = 1'b1;
            phase_d = PH_RD_PRE; wait_d = half_m1;
          end
          i2cblm_pkg::CMD_ACK, i2cblm_pkg::CMD_NACK: begin
            scl_d = 1'b0;
            phase_d = PH_AK_A; wait_d = full_m1;
          end
          default: ;
        endcase
      end
    end else if (phase_q == PH_WA_POLL) begin
      // acknowledge polling
      if (!in_item_i.sda_in) begin
        ack_d = 1'b1; phase_d = PH_WA_C; wait_d = full_m1;
      end else if (poll_q >= ack_timeout_q) begin
        ack_d = 1'b0; phase_d = PH_WA_C; wait_d = full_m1;
      end else begin
        poll_d = poll_q + 1'b1;
      end
    end else if (wait_q != '0) begin
      wait_d = wait_q - 1'b1;
    end else begin
      // phase done: step to the next one
      wait_d = full_m1;
      case (phase_q)
        PH_ST_A:  begin sda_d = 1'b0; phase_d = PH_ST_B; end
        PH_ST_B:  begin sda_d = 1'b0; phase_d = PH_ST_C; end
        PH_SP_A:  begin sda_d = 1'b0; phase_d = PH_SP_B; end
        PH_SP_B:  begin scl_d = 1'b1; phase_d = PH_SP_C; end
        PH_SP_C:  begin sda_d = 1'b1; phase_d = PH_SP_D; end
        PH_WA_A: begin
          scl_d = 1'b1; poll_d = '0; phase_d = PH_WA_POLL; wait_d = '0;
        end
        PH_WA_C:  begin scl_d = 1'b0; phase_d = PH_WA_D; end
        PH_WA_D: begin
          phase_d = PH_IDLE; wait_d = '0; pulse_ack = 1'b1;
        end
        PH_WR_PRE: begin scl_d = 1'b0; bit_d = '0; phase_d = PH_WR_LOW; end
        PH_WR_LOW: begin sda_d = shift_q[7]; phase_d = PH_WR_DATA; end
        PH_WR_DATA: begin scl_d = 1'b1; phase_d = PH_WR_HIGH; end
        PH_WR_HIGH: begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_inc;
          scl_d   = 1'b0;
          phase_d = (bit_inc >= 4'd8) ? PH_WR_END : PH_WR_LOW;
        end
        PH_RD_PRE: begin scl_d = 1'b0; bit_d = '0; phase_d = PH_RD_LOW; end
        PH_RD_LOW: begin scl_d = 1'b1; phase_d = PH_RD_HIGH; end
        PH_RD_HIGH: begin
          shift_d = shift_rd;
          bit_d   = bit_inc;
          if (bit_inc >= 4'd8) begin
            rbyte_d = shift_rd; pulse_read = 1'b1;
            phase_d = PH_IDLE; wait_d = '0;
          end else begin
            scl_d = 1'b0; phase_d = PH_RD_LOW;
          end
        end
        PH_AK_A: begin drive_d = 1'b1; phase_d = PH_AK_B; end
        PH_AK_B: begin
          sda_d   = (cmd_q == i2cblm_pkg::CMD_NACK);
          phase_d = PH_AK_C;
        end
        PH_AK_C: begin scl_d = 1'b1; phase_d = PH_AK_D; end
        PH_AK_D: begin
          scl_d   = 1'b0; phase_d = PH_AK_E;
          // ack holds its low phase for half a unit, nack for a full one
          wait_d  = (cmd_q != i2cblm_pkg::CMD_NACK) ? half_m1 : full_m1;
        end
        default: begin phase_d = PH_IDLE; wait_d = '0; end
      endcase
    end
  end

  // result item for this tick
  always_comb begin
    out_d.scl_level  = scl_d;
    out_d.sda_level  = sda_d;
    out_d.sda_drive  = drive_d;
    out_d.ready_res  = (phase_d == PH_IDLE);
    out_d.read_data  = rbyte_d;
    out_d.read_valid = pulse_read;
    out_d.ack_valid  = pulse_ack;
    out_d.ack_seen   = ack_d;
  end

  assign out_valid_d = accept ? 1'b1 : (out_valid_q && out_stall_i);

  // state, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      cmd_q         <= i2cblm_pkg::CMD_NONE;
      bit_q         <= '0;
      shift_q       <= '0;
      wait_q        <= '0;
      poll_q        <= '0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      drive_q       <= 1'b1;
      rbyte_q       <= '0;
      ack_q         <= 1'b0;
      wait_ticks_q  <= i2cblm_pkg::WAIT_TICKS_RST;
      ack_timeout_q <= i2cblm_pkg::ACK_TIMEOUT_RST;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        wait_q  <= wait_d;
        poll_q  <= poll_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        drive_q <= drive_d;
        rbyte_q <= rbyte_d;
        ack_q   <= ack_d;
        out_q   <= out_d;
      end
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == i2cblm_pkg::CFG_WAIT_TICKS) begin
          wait_ticks_q <= cfg_data_i[WaitW-1:0];
        end else if (cfg_index_i == i2cblm_pkg::CFG_ACK_TIMEOUT) begin
          ack_timeout_q <= cfg_data_i[PollW-1:0];
        end
      end
    end
  end

  // checks
`include "i2c_bit_level_master_macros.svh"

  `I2CBLM_ASSERT(a_ready_matches_phase, out_valid_q, out_q.ready_res == (phase_q == PH_IDLE), "ready flag disagrees with phase")
  `I2CBLM_ASSERT(a_pulse_ends_command, out_valid_q && (out_q.read_valid || out_q.ack_valid), out_q.ready_res && !(out_q.read_valid && out_q.ack_valid), "completion pulse without return to idle")
  `I2CBLM_ASSERT(a_poll_pins, phase_q == PH_WA_POLL, scl_q && !drive_q, "ack poll with SCL low or SDA driven")
  `I2CBLM_ASSERT_NEXT(a_stall_holds_state, out_valid_q && out_stall_i, $stable(phase_q) && $stable(wait_q), "sequencer moved while result stalled")

endmodule

// ===== bench/i2cblm_bus_checker.sv =====
// Checker for the I2C bit-level master: watches the tick, result and register
// channels, predicts every result item and compares it field by field.
// Depends on i2cblm_pkg.
module i2cblm_bus_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  i2cblm_pkg::in_item_t              in_item_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  i2cblm_pkg::out_item_t             out_item_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [i2cblm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [i2cblm_pkg::CfgDataW-1:0]   cfg_data_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output logic                              bus_idle_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C,
    PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
    PH_WA_A, PH_WA_POLL, PH_WA_C, PH_WA_D,
    PH_WR_PRE, PH_WR_LOW, PH_WR_DATA, PH_WR_HIGH, PH_WR_END,
    PH_RD_PRE, PH_RD_LOW, PH_RD_HIGH,
    PH_AK_A, PH_AK_B, PH_AK_C, PH_AK_D, PH_AK_E
  } phase_e;

  localparam int unsigned WaitW = i2cblm_pkg::WaitW;
  localparam int unsigned PollW = i2cblm_pkg::PollW;

  // register copies
  logic [WaitW-1:0] wait_ticks;
  logic [PollW-1:0] ack_timeout;

  // sequencer copy
  phase_e            phase_q;
  i2cblm_pkg::cmd_e  active_cmd;
  logic [3:0]        bit_idx;
  logic [7:0]        shifter;
  logic [WaitW-1:0]  wait_cnt;
  logic [PollW-1:0]  poll_cnt;
  logic              scl_q, sda_q, drive_q;
  logic [7:0]        rd_byte;
  logic              ack_q;
  logic              rd_pulse, ack_pulse;

  i2cblm_pkg::out_item_t expected_pins_q[$];

  assign bus_idle_o = (phase_q == PH_IDLE);

  function automatic void reset_model();
    wait_ticks  = i2cblm_pkg::WAIT_TICKS_RST;
    ack_timeout = i2cblm_pkg::ACK_TIMEOUT_RST;
    phase_q     = PH_IDLE;
    active_cmd  = i2cblm_pkg::CMD_NONE;
    bit_idx     = '0;
    shifter     = '0;
    wait_cnt    = '0;
    poll_cnt    = '0;
    scl_q       = 1'b1;
    sda_q       = 1'b1;
    drive_q     = 1'b1;
    rd_byte     = '0;
    ack_q       = 1'b0;
    rd_pulse    = 1'b0;
    ack_pulse   = 1'b0;
  endfunction

  // a phase lasts one wait unit, or half of one; never less than a tick
  function automatic void enter_phase(phase_e ph, bit half);
    logic [WaitW-1:0] len;
    len = half ? (wait_ticks >> 1) : wait_ticks;
    if (len == '0) len = WaitW'(1);
    phase_q  = ph;
    wait_cnt = len - 1'b1;
  endfunction

  function automatic void go_idle();
    phase_q  = PH_IDLE;
    wait_cnt = '0;
  endfunction

  function automatic void start_command(i2cblm_pkg::cmd_e c, logic [7:0] d);
    active_cmd = c;
    case (c)
      i2cblm_pkg::CMD_START: begin
        drive_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
        enter_phase(PH_ST_A, 1'b0);
      end
      i2cblm_pkg::CMD_STOP: begin
        drive_q = 1'b1; scl_q = 1'b0;
        enter_phase(PH_SP_A, 1'b0);
      end
      i2cblm_pkg::CMD_WRITE: begin
        drive_q = 1'b1; shifter = d;
        enter_phase(PH_WR_PRE, 1'b1);
      end
      i2cblm_pkg::CMD_WAIT_ACK: begin
        drive_q = 1'b0; scl_q = 1'b0; sda_q = 1'b1;
        enter_phase(PH_WA_A, 1'b0);
      end
      i2cblm_pkg::CMD_READ: begin
        drive_q = 1'b0; sda_q = 1'b1;
        enter_phase(PH_RD_PRE, 1'b1);
      end
      i2cblm_pkg::CMD_ACK, i2cblm_pkg::CMD_NACK: begin
        scl_q = 1'b0;
        enter_phase(PH_AK_A, 1'b0);
      end
      default: ;
    endcase
  endfunction

  // end of a phase: set the next pin levels and move on
  function automatic void advance_phase(logic sda);
    case (phase_q)
      PH_ST_A: begin sda_q = 1'b0; enter_phase(PH_ST_B, 1'b0); end
      PH_ST_B: begin sda_q = 1'b0; enter_phase(PH_ST_C, 1'b0); end
      PH_SP_A: begin sda_q = 1'b0; enter_phase(PH_SP_B, 1'b0); end
      PH_SP_B: begin scl_q = 1'b1; enter_phase(PH_SP_C, 1'b0); end
      PH_SP_C: begin sda_q = 1'b1; enter_phase(PH_SP_D, 1'b0); end
      PH_WA_A: begin
        scl_q = 1'b1; poll_cnt = '0;
        phase_q = PH_WA_POLL; wait_cnt = '0;
      end
      PH_WA_C: begin scl_q = 1'b0; enter_phase(PH_WA_D, 1'b0); end
      PH_WA_D: begin go_idle(); ack_pulse = 1'b1; end
      PH_WR_PRE: begin scl_q = 1'b0; bit_idx = '0; enter_phase(PH_WR_LOW, 1'b0); end
      PH_WR_LOW: begin sda_q = shifter[7]; enter_phase(PH_WR_DATA, 1'b0); end
      PH_WR_DATA: begin scl_q = 1'b1; enter_phase(PH_WR_HIGH, 1'b0); end
      PH_WR_HIGH: begin
        shifter = {shifter[6:0], 1'b0};
        bit_idx = bit_idx + 1'b1;
        scl_q   = 1'b0;
        enter_phase((bit_idx >= 4'd8) ? PH_WR_END : PH_WR_LOW, 1'b0);
      end
      PH_RD_PRE: begin scl_q = 1'b0; bit_idx = '0; enter_phase(PH_RD_LOW, 1'b0); end
      PH_RD_LOW: begin scl_q = 1'b1; enter_phase(PH_RD_HIGH, 1'b0); end
      PH_RD_HIGH: begin
        // sample the bit at the end of the SCL high phase
        shifter = {shifter[6:0], sda};
        bit_idx = bit_idx + 1'b1;
        if (bit_idx >= 4'd8) begin
          rd_byte  = shifter;
          rd_pulse = 1'b1;
          go_idle();
        end else begin
          scl_q = 1'b0;
          enter_phase(PH_RD_LOW, 1'b0);
        end
      end
      PH_AK_A: begin drive_q = 1'b1; enter_phase(PH_AK_B, 1'b0); end
      PH_AK_B: begin
        sda_q = (active_cmd == i2cblm_pkg::CMD_NACK);
        enter_phase(PH_AK_C, 1'b0);
      end
      PH_AK_C: begin scl_q = 1'b1; enter_phase(PH_AK_D, 1'b0); end
      PH_AK_D: begin
        scl_q = 1'b0;
        enter_phase(PH_AK_E, active_cmd != i2cblm_pkg::CMD_NACK);
      end
      default: go_idle();
    endcase
  endfunction

  // one tick through the sequencer, giving the pins and status after it
  function automatic i2cblm_pkg::out_item_t predict_tick(i2cblm_pkg::in_item_t it);
    i2cblm_pkg::out_item_t res;
    rd_pulse  = 1'b0;
    ack_pulse = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (it.command != i2cblm_pkg::CMD_NONE) start_command(it.command, it.write_data);
    end else if (phase_q == PH_WA_POLL) begin
      if (!it.sda_in) begin
        ack_q = 1'b1;
        enter_phase(PH_WA_C, 1'b0);
      end else if (poll_cnt >= ack_timeout) begin
        ack_q = 1'b0;
        enter_phase(PH_WA_C, 1'b0);
      end else begin
        poll_cnt = poll_cnt + 1'b1;
      end
    end else if (wait_cnt != '0) begin
      wait_cnt = wait_cnt - 1'b1;
    end else begin
      advance_phase(it.sda_in);
    end
    res.scl_level  = scl_q;
    res.sda_level  = sda_q;
    res.sda_drive  = drive_q;
    res.ready_res  = (phase_q == PH_IDLE);
    res.read_data  = rd_byte;
    res.read_valid = rd_pulse;
    res.ack_valid  = ack_pulse;
    res.ack_seen   = ack_q;
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic compare_result(i2cblm_pkg::out_item_t got);
    i2cblm_pkg::out_item_t want;
    if (expected_pins_q.size() == 0) begin
      $error("result item with no expected item waiting");
      fail_count_o++;
    end else begin
      want = expected_pins_q.pop_front();
      check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      check_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
      check_field("read_data", want.read_data, got.read_data);
      check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      check_field("ack_valid", 8'(want.ack_valid), 8'(got.ack_valid));
      check_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
    end
  endtask

  // results are checked before this edge's tick is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      expected_pins_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_item_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == i2cblm_pkg::CFG_WAIT_TICKS) begin
          wait_ticks = cfg_data_i[WaitW-1:0];
        end else if (cfg_index_i == i2cblm_pkg::CFG_ACK_TIMEOUT) begin
          ack_timeout = cfg_data_i[PollW-1:0];
        end
      end
      if (in_valid_i && !in_stall_i) expected_pins_q.push_back(predict_tick(in_item_i));
      pending_o = expected_pins_q.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the I2C bit-level master bench: clock, reset, tick and register
// stimulus, result stalls and the verdict.
// Depends on i2cblm_pkg, i2c_bit_level_master and i2cblm_bus_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 20_000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned BlockTicks = 50;
  localparam int unsigned WaitW      = i2cblm_pkg::WaitW;
  localparam int unsigned PollW      = i2cblm_pkg::PollW;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  i2cblm_pkg::in_item_t                in_item_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  i2cblm_pkg::out_item_t               out_item_o;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [i2cblm_pkg::CfgIdxW-1:0]      cfg_index_i;
  logic [i2cblm_pkg::CfgDataW-1:0]     cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  logic        bus_idle;

  // stimulus knobs and tallies
  bit               gaps_on = 1'b1;
  bit               rx_idle_on = 1'b1;
  bit               hold_req = 1'b0;
  i2cblm_pkg::cmd_e cur_cmd = i2cblm_pkg::CMD_NONE;
  bit               ack_absent = 1'b0;
  logic [PollW-1:0] cur_ack_timeout = i2cblm_pkg::ACK_TIMEOUT_RST;
  int unsigned      ticks_sent = 0;
  int unsigned      cmds_sent = 0;
  int unsigned      settings_used = 1;

  i2c_bit_level_master dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  i2cblm_bus_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .bus_idle_o   (bus_idle)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", CycleLimit, pending);
    $display("[i2c_bit_level_master] ERROR");
    $finish;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_stall_i <= rx_idle_on && ($urandom_range(99) < 19);
      end
    end
  end

  // SDA as a slave would drive it: during wait-ack pull low now and then,
  // or never when the acknowledge is meant to time out
  function automatic logic tick_sda();
    if (cur_cmd == i2cblm_pkg::CMD_WAIT_ACK) begin
      return ack_absent ? 1'b1 : ($urandom_range(7) != 0);
    end
    return 1'($urandom_range(1));
  endfunction

  function automatic i2cblm_pkg::cmd_e random_cmd();
    return i2cblm_pkg::cmd_e'($urandom_range(1, 7));
  endfunction

  function automatic i2cblm_pkg::cmd_e noise_cmd();
    if ($urandom_range(3) == 0) return random_cmd();
    return i2cblm_pkg::CMD_NONE;
  endfunction

  function automatic bit random_no_ack();
    return (cur_ack_timeout <= PollW'(64)) && ($urandom_range(3) == 0);
  endfunction

  // offer one tick item, with an optional gap first; returns after acceptance
  task automatic send_tick(i2cblm_pkg::cmd_e c, logic [7:0] d, logic s);
    i2cblm_pkg::in_item_t it;
    it.command    = c;
    it.write_data = d;
    it.sda_in     = s;
    if (gaps_on && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 19);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // start a bus command from idle and tick until the sequencer is idle again
  task automatic issue(i2cblm_pkg::cmd_e c, logic [7:0] d, bit no_ack = 1'b0);
    int lead;
    lead = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (lead) send_tick(i2cblm_pkg::CMD_NONE, 8'($urandom), tick_sda());
    cur_cmd    = c;
    ack_absent = no_ack;
    send_tick(c, d, tick_sda());
    cmds_sent++;
    while (!bus_idle) send_tick(noise_cmd(), 8'($urandom), tick_sda());
  endtask

  // stop offering ticks until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // both registers, back to back, with the block drained and idle
  task automatic set_timing(logic [WaitW-1:0] wt, logic [PollW-1:0] to);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= i2cblm_pkg::CFG_WAIT_TICKS;
    cfg_data_i  <= {2'b00, wt};
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i <= i2cblm_pkg::CFG_ACK_TIMEOUT;
    cfg_data_i  <= to;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_ack_timeout = to;
    settings_used++;
  endtask

  // short wait units keep each command to a few dozen ticks
  task automatic random_timing();
    logic [WaitW-1:0] wt;
    wt = WaitW'($urandom_range(0, 2));
    set_timing(wt, PollW'($urandom_range(0, 6)));
  endtask

  initial begin
    int unsigned block_start;
    bit paused;
    bit held;
    paused      = 1'b0;
    held        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset timing: a start with the default wait unit
    issue(i2cblm_pkg::CMD_START, 8'h00);

    // shortest wait that needs no clamping, zero timeout: one high sample gives up at once
    set_timing(16'd2, '0);
    issue(i2cblm_pkg::CMD_WAIT_ACK, 8'hFF, 1'b1);
    issue(i2cblm_pkg::CMD_ACK, 8'hFF);
    issue(i2cblm_pkg::CMD_NACK, 8'h00);
    issue(i2cblm_pkg::CMD_STOP, 8'h00);

    // wait units below two clamp to one tick per phase
    set_timing(16'd0, 18'd3);
    issue(i2cblm_pkg::CMD_WRITE, 8'h5A);
    issue(i2cblm_pkg::CMD_WAIT_ACK, 8'h00, 1'b1);
    set_timing(16'd1, 18'd1);
    issue(i2cblm_pkg::CMD_READ, 8'h00);
    issue(i2cblm_pkg::CMD_ACK, 8'h00);

    // largest timeout, acknowledged before it runs out
    set_timing(16'd2, 18'h3FFFF);
    issue(i2cblm_pkg::CMD_WAIT_ACK, 8'h00);

    // random commands under a new timing per block
    for (int blk = 0; blk < 4; blk++) begin
      random_timing();
      gaps_on     = (blk != 2);
      rx_idle_on  = (blk != 2);
      block_start = ticks_sent;
      while (ticks_sent - block_start < BlockTicks) begin
        if (blk == 1 && ticks_sent - block_start > 10 && !held) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        if (blk == 3 && ticks_sent - block_start > 20 && !paused) begin
          drain();
          paused = 1'b1;
        end
        issue(random_cmd(), 8'($urandom), random_no_ack());
      end
    end
    gaps_on    = 1'b1;
    rx_idle_on = 1'b1;

    drain();
    repeat (4) @(negedge clk_i);
    $display("Ran %0d ticks carrying %0d bus commands over %0d timing settings,",
             ticks_sent, cmds_sent, settings_used);
    $display("with clamped wait units, ack timeouts and a long result hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("[i2c_bit_level_master] OK");
    end else begin
      $display("[i2c_bit_level_master] ERROR");
    end
    $finish;
  end

endmodule
